FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge out of reset
`define CQF_ASSERT(name, clock, rstn, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!(rstn)) prop) else $error(msg);

// Condition that must never be seen out of reset
`define CQF_ASSERT_NEVER(name, clock, rstn, cond, msg) \
    name: assert property (@(posedge clock) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/cqf_pkg.sv
// ----------------------------------------------------------------------------
// cqf_pkg
// Types and constants shared by the queue controller, datapath and top level.
// ----------------------------------------------------------------------------
package cqf_pkg;

    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    // Operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ   = 3'd0,
        KIND_DEQ   = 3'd1,
        KIND_PEEK  = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_DUMP  = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_t;

    // Input item
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } item_t;

    // Result item
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              mem_write;
        logic              tail_adv;
        logic              head_adv;
        logic              count_inc;
        logic              count_dec;
        logic              clear;
        logic              dump_load;
        logic              dump_step;
        logic              rd_dump;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
        logic              res_data;
        logic              res_last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic final_word;
    } stat_t;

endpackage

FILE: hw/rtl/circular_queue_fifo.sv
// ----------------------------------------------------------------------------
// circular_queue_fifo
// Ring-buffer queue of signed 32-bit words with programmable capacity.
//
//   Channel  Signals                       Transfer when
//   -------  ----------------------------  ----------------------------
//   item     start, busy, item             start high and busy low
//   result   result_valid, result          result_valid high (one cycle)
//   config   cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
//
// Enqueue, dequeue, peek and clear: the result appears the cycle after the
// item transfer and the next item may go in that same cycle.
// A dump of n words gives one word per cycle from the single memory read
// port, holding busy after the item transfer until the last word is read.
// Reset empties the queue and sets capacity to the depth, capped at 31; no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_queue_fifo
    import cqf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Capacity writes are taken whenever no dump is running
    assign cfg_ready = !busy;

    cqf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    cqf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .wr_value     (item.value),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // A running dump delivers a word every cycle
    `CQF_ASSERT(a_dump_streams, clk, rst_n, busy |=> result_valid, "dump stalled")

    // A result not marked last is followed at once by another
    `CQF_ASSERT(a_last_closes, clk, rst_n, (result_valid && !result.last) |=> result_valid, "dump cut short")

    // The queue cannot read as both empty and full
    `CQF_ASSERT_NEVER(a_empty_full, clk, rst_n, stat.empty && stat.full, "count inconsistent")

    // Unused operation codes give no result
    `CQF_ASSERT(a_unused_silent, clk, rst_n, (start && !busy && (item.kind > KIND_DUMP)) |=> !result_valid, "result for unused code")

endmodule

FILE: hw/rtl/cqf_ctrl.sv
// ----------------------------------------------------------------------------
// cqf_ctrl
// Operation decoder and dump sequencer for the circular queue.
// ----------------------------------------------------------------------------
module cqf_ctrl
    import cqf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  stat_t             stat,
    output logic              busy,
    output cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a dump of more than one word walks the ring
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (kind == KIND_DUMP) && !stat.empty && !stat.single)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (stat.final_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg == ST_DUMP);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind)
                        KIND_ENQ:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.res_status = STATUS_OK;
                                cmd.mem_write  = 1'b1;
                                cmd.tail_adv   = 1'b1;
                                cmd.count_inc  = 1'b1;
                            end
                        end
                        KIND_DEQ:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_last = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.res_status = STATUS_OK;
                                cmd.head_adv   = 1'b1;
                                cmd.count_dec  = 1'b1;
                            end
                        end
                        KIND_PEEK:
                        begin
                            // head word is read this cycle
                            cmd.res_load   = 1'b1;
                            cmd.res_last   = 1'b1;
                            cmd.res_status = stat.empty ? STATUS_EMPTY : STATUS_OK;
                            cmd.res_data   = !stat.empty;
                        end
                        KIND_CLEAR:
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_last   = 1'b1;
                            cmd.res_status = STATUS_OK;
                            cmd.clear      = 1'b1;
                        end
                        KIND_DUMP:
                        begin
                            cmd.res_load = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                                cmd.res_last   = 1'b1;
                            end
                            else
                            begin
                                // first word read at head, walker primed behind it
                                cmd.res_status = STATUS_OK;
                                cmd.res_data   = 1'b1;
                                cmd.res_last   = stat.single;
                                cmd.dump_load  = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused codes: no result, no change
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                cmd.rd_dump    = 1'b1;
                cmd.dump_step  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = STATUS_OK;
                cmd.res_data   = 1'b1;
                cmd.res_last   = stat.final_word;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/cqf_datapath.sv
// ----------------------------------------------------------------------------
// cqf_datapath
// Ring storage, pointers, capacity register and registered result.
// ----------------------------------------------------------------------------
module cqf_datapath
    import cqf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CAP_W-1:0]         cfg_data,
    input  logic signed [DATA_W-1:0] wr_value,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    output logic                     result_valid,
    output result_t                  result
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_MAX = (1 << CAP_W) - 1;
    localparam int CAP_RST = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [CAP_W-1:0]  capacity_reg;
    logic [CAP_W-1:0]  capacity_next;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [PTR_W-1:0]  dump_idx_reg;
    logic [PTR_W-1:0]  dump_idx_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;

    logic              res_valid_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic              res_last_reg;
    logic              res_data_sel_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic [PTR_W-1:0]  rd_addr;

    // Step a pointer by one, wrapping at the active capacity
    function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] nxt;
        nxt = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
        if (nxt >= (CNT_W+1)'(cap))
        begin
            return '0;
        end
        return nxt[PTR_W-1:0];
    endfunction

    // Active capacity: zero acts as one, anything above the depth as the depth
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(capacity_reg) > 32'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg >= cap_eff);
        stat.single     = (count_reg == CNT_W'(1));
        stat.final_word = (remain_reg == CNT_W'(1));
    end

    assign rd_addr = cmd.rd_dump ? dump_idx_reg : head_reg;

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[tail_reg] <= wr_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Pointer, count and capacity update; a capacity write empties the queue
    always_comb
    begin
        capacity_next = capacity_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        remain_next   = remain_reg;

        if (cfg_write)
        begin
            capacity_next = cfg_data;
            head_next     = '0;
            tail_next     = '0;
            count_next    = '0;
        end
        else
        begin
            if (cmd.tail_adv)
            begin
                tail_next = ring_adv(tail_reg, cap_eff);
            end
            if (cmd.head_adv)
            begin
                head_next = ring_adv(head_reg, cap_eff);
            end
            if (cmd.count_inc)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd.count_dec)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            if (cmd.clear)
            begin
                tail_next  = head_reg;
                count_next = '0;
            end
        end

        // Dump walker
        if (cmd.dump_load)
        begin
            dump_idx_next = ring_adv(head_reg, cap_eff);
            remain_next   = count_reg - CNT_W'(1);
        end
        else if (cmd.dump_step)
        begin
            dump_idx_next = ring_adv(dump_idx_reg, cap_eff);
            remain_next   = remain_reg - CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_W'(CAP_RST);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            remain_reg    <= remain_next;
            res_valid_reg <= cmd.res_load;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg   <= cmd.res_status;
            res_last_reg     <= cmd.res_last;
            res_data_sel_reg <= cmd.res_data;
        end
    end

    // Result port; stored word comes straight from the read register
    assign result_valid  = res_valid_reg;
    assign result.status = res_status_reg;
    assign result.last   = res_last_reg;
    assign result.data   = res_data_sel_reg ? $signed(rd_data_reg) : '0;

endmodule

FILE: tb/tb_circular_queue_fifo.sv
// ----------------------------------------------------------------------------
// tb_circular_queue_fifo
// Self-checking bench for the ring-buffer queue of signed 32-bit words.
//
// A directed sequence covers word extremes, every operation and the corner
// cases: full, empty, clear and unused operation codes. Random phases follow,
// each opened by a capacity write (some out of range) and run with its own
// sender idle rate. A behavioural ring model predicts every reply; the monitor
// checks each reply field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_queue_fifo;
    import cqf_pkg::*;

    localparam int RING_DEPTH    = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    // One pending operation: either an item or a capacity write
    typedef struct {
        bit               is_cfg;
        item_t            op_item;
        logic [CAP_W-1:0] cap;
        int               idle_pct;
    } queue_op_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    item_t            item_in   = '0;
    logic             result_valid;
    result_t          result_out;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    queue_op_t pending_ops[$];
    result_t   queue_replies[$];
    int        sender_idle_pct = 0;
    int        quiet_cycles    = 0;
    int        cycle_count     = 0;
    int        errors          = 0;

    // Ring model state
    logic signed [DATA_W-1:0] ring_store [RING_DEPTH];
    logic [3:0]               ring_head;
    logic [3:0]               ring_tail;
    logic [4:0]               ring_count;
    logic [CAP_W-1:0]         ring_cap_reg;

    circular_queue_fifo #(.DEPTH(RING_DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item_in),
        .result_valid (result_valid),
        .result       (result_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Capacity in force: zero acts as one, anything above the depth as the depth
    function automatic int effective_capacity();
        if (ring_cap_reg == 0)
            return 1;
        if (ring_cap_reg > RING_DEPTH)
            return RING_DEPTH;
        return int'(ring_cap_reg);
    endfunction

    function automatic logic [3:0] ring_next(logic [3:0] idx);
        int nxt;
        nxt = int'(idx) + 1;
        return (nxt >= effective_capacity()) ? 4'd0 : nxt[3:0];
    endfunction

    function automatic result_t make_reply(status_t st, logic signed [DATA_W-1:0] word,
                                           logic is_last);
        result_t r;
        r.status = st;
        r.data   = word;
        r.last   = is_last;
        return r;
    endfunction

    task automatic write_capacity(logic [CAP_W-1:0] v);
        ring_cap_reg = v;
        ring_head    = '0;
        ring_tail    = '0;
        ring_count   = '0;
    endtask

    // Work out the replies caused by one accepted item
    task automatic predict_queue_reply(item_t it);
        logic [3:0] idx;
        int         n;
        case (it.kind)
            KIND_ENQ:
            begin
                if (ring_count >= effective_capacity())
                    queue_replies.push_back(make_reply(STATUS_FULL, '0, 1'b1));
                else
                begin
                    ring_store[ring_tail] = it.value;
                    ring_tail  = ring_next(ring_tail);
                    ring_count = ring_count + 5'd1;
                    queue_replies.push_back(make_reply(STATUS_OK, '0, 1'b1));
                end
            end
            KIND_DEQ:
            begin
                if (ring_count == 0)
                    queue_replies.push_back(make_reply(STATUS_EMPTY, '0, 1'b1));
                else
                begin
                    ring_head  = ring_next(ring_head);
                    ring_count = ring_count - 5'd1;
                    queue_replies.push_back(make_reply(STATUS_OK, '0, 1'b1));
                end
            end
            KIND_PEEK:
            begin
                if (ring_count == 0)
                    queue_replies.push_back(make_reply(STATUS_EMPTY, '0, 1'b1));
                else
                    queue_replies.push_back(make_reply(STATUS_OK, ring_store[ring_head], 1'b1));
            end
            KIND_CLEAR:
            begin
                ring_tail  = ring_head;
                ring_count = '0;
                queue_replies.push_back(make_reply(STATUS_OK, '0, 1'b1));
            end
            KIND_DUMP:
            begin
                if (ring_count == 0)
                    queue_replies.push_back(make_reply(STATUS_EMPTY, '0, 1'b1));
                else
                begin
                    idx = ring_head;
                    for (n = 0; n < ring_count; n++)
                    begin
                        queue_replies.push_back(make_reply(STATUS_OK, ring_store[idx],
                                                           n + 1 == ring_count));
                        idx = ring_next(idx);
                    end
                end
            end
            default:
            begin
                // unused codes are ignored by the block
            end
        endcase
    endtask

    // Driver: offers the next pending operation, holds it until its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            item_in      <= '0;
            cfg_valid    <= 1'b0;
            cfg_data     <= '0;
            quiet_cycles <= 0;
            ring_head    = '0;
            ring_tail    = '0;
            ring_count   = '0;
            ring_cap_reg = CAP_W'(RING_DEPTH);
        end
        else
        begin
            // account for transfers completed at this edge
            if (start && !busy)
                predict_queue_reply(item_in);
            if (cfg_valid && cfg_ready)
                write_capacity(cfg_data);

            // idle time seen by the block, used before a capacity write
            if ((start && !busy) || result_valid || busy)
                quiet_cycles <= 0;
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles <= quiet_cycles + 1;

            if ((start && busy) || (cfg_valid && !cfg_ready))
            begin
                // offered transfer not yet taken: hold it
            end
            else if (pending_ops.size() == 0)
            begin
                start     <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else if (pending_ops[0].is_cfg)
            begin
                // capacity writes only once the queue has gone quiet
                start <= 1'b0;
                if (queue_replies.size() == 0 && quiet_cycles >= SETTLE_CYCLES &&
                    !start && !cfg_valid)
                begin
                    cfg_valid       <= 1'b1;
                    cfg_data        <= pending_ops[0].cap;
                    sender_idle_pct = pending_ops[0].idle_pct;
                    void'(pending_ops.pop_front());
                end
                else
                    cfg_valid <= 1'b0;
            end
            else
            begin
                cfg_valid <= 1'b0;
                if ($urandom_range(99) < sender_idle_pct)
                    start <= 1'b0;
                else
                begin
                    start   <= 1'b1;
                    item_in <= pending_ops.pop_front().op_item;
                end
            end
        end
    end

    // Monitor: every strobed reply is checked against the oldest prediction
    always @(posedge clk)
    begin
        result_t exp_reply;
        if (rst_n && result_valid)
        begin
            if (queue_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual %0d/%0d/%0d", $time,
                         result_out.status, result_out.data, result_out.last);
                errors++;
            end
            else
            begin
                exp_reply = queue_replies.pop_front();
                if (result_out.status !== exp_reply.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             exp_reply.status, result_out.status);
                    errors++;
                end
                if (result_out.data !== exp_reply.data)
                begin
                    $display("%0t: data mismatch, expected %0d, actual %0d", $time,
                             exp_reply.data, result_out.data);
                    errors++;
                end
                if (result_out.last !== exp_reply.last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b", $time,
                             exp_reply.last, result_out.last);
                    errors++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_item(logic [KIND_W-1:0] k, logic signed [DATA_W-1:0] v);
        queue_op_t op;
        op.is_cfg   = 1'b0;
        op.op_item  = '{kind: k, value: v};
        op.cap      = '0;
        op.idle_pct = 0;
        pending_ops.push_back(op);
    endtask

    task automatic add_capacity(logic [CAP_W-1:0] c, int idle);
        queue_op_t op;
        op.is_cfg   = 1'b1;
        op.op_item  = '0;
        op.cap      = c;
        op.idle_pct = idle;
        pending_ops.push_back(op);
    endtask

    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus and end of run
    initial
    begin
        logic [CAP_W-1:0] phase_caps [10];
        int               phase_idle [4];
        int               ph;
        int               n;
        int               goal;
        int               enq_w;
        int               pick;

        phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd3, 5'd12, 5'd17, 5'd2, 5'd9};
        phase_idle = '{0, 51, 0, 32};

        // directed: extremes and corner cases at the reset capacity
        add_item(KIND_ENQ, 32'sh7FFF_FFFF);
        add_item(KIND_ENQ, 32'sh8000_0000);
        add_item(KIND_ENQ, '0);
        add_item(KIND_ENQ, -32'sd1);
        add_item(KIND_PEEK, '0);
        add_item(KIND_DUMP, '0);
        add_item(KIND_DEQ, '0);
        add_item(KIND_PEEK, -32'sd1);
        add_item(KIND_DUMP, '0);
        add_item(KIND_CLEAR, '0);
        add_item(KIND_DUMP, '0);
        add_item(KIND_DEQ, '0);
        add_item(KIND_PEEK, '0);
        add_item(3'd5, 32'sh1234_5678);
        add_item(3'd6, '0);
        add_item(3'd7, -32'sd1);
        // single-entry ring: full on the second enqueue
        add_capacity(5'd1, 0);
        add_item(KIND_ENQ, 32'sh5A5A_A5A5);
        add_item(KIND_ENQ, 32'sh0F0F_0F0F);
        add_item(KIND_DUMP, '0);
        add_item(KIND_DEQ, '0);
        add_item(KIND_DEQ, '0);

        // random phases, each with its own capacity and idle rate
        for (ph = 0; ph < 10; ph++)
        begin
            add_capacity(phase_caps[ph], phase_idle[ph % 4]);
            goal  = (phase_caps[ph] >= 12) ? 18 : 11;
            enq_w = (ph % 2 == 0) ? 65 : 40;
            n     = 0;
            while (n < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    add_item(3'($urandom_range(7, 5)), random_word());
                else
                begin
                    n++;
                    if (pick < 3 + enq_w)
                        add_item(KIND_ENQ, random_word());
                    else
                    begin
                        pick = $urandom_range(99);
                        if (pick < 50)
                            add_item(KIND_DEQ, random_word());
                        else if (pick < 72)
                            add_item(KIND_PEEK, random_word());
                        else if (pick < 92)
                            add_item(KIND_DUMP, random_word());
                        else
                            add_item(KIND_CLEAR, random_word());
                    end
                end
            end
        end

        // wait for every operation to go in and every reply to come back
        @(negedge clk);
        while (!(rst_n && pending_ops.size() == 0 && !start && !cfg_valid &&
                 queue_replies.size() == 0))
            @(negedge clk);
        repeat (RING_DEPTH + SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
